@@ src/bdtt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package bdtt_pkg;

    typedef struct packed {
        logic               action;
        logic [47:0]        mac;
        logic signed [7:0]  rssi;
        logic [1:0]         addr_type;
        logic [31:0]        time_ms;
        logic [1:0]         mfr_len;
        logic [15:0]        company_id;
        logic [7:0]         mfr_subtype;
        logic [5:0]         read_index;
    } in_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [5:0]         entry_index;
        logic [6:0]         entry_total;
        logic [47:0]        out_mac;
        logic signed [7:0]  out_rssi;
        logic [1:0]         out_addr_type;
        logic [31:0]        out_last_seen;
        logic               out_tracker;
    } out_t;

    typedef struct packed {
        logic [47:0]        mac;
        logic signed [7:0]  rssi;
        logic [1:0]         addr_type;
        logic [31:0]        last_seen;
        logic               tracker;
    } entry_t;

    // controller to datapath
    typedef struct packed {
        logic start;
        logic scan;
        logic emit_read;
        logic emit_update;
        logic emit_append;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic in_read;
        logic pend;
        logic match;
        logic more;
        logic out_free;
    } sts_t;

    localparam logic       ACT_READ     = 1'b1;

    localparam logic [2:0] ST_UPDATED   = 3'd0;
    localparam logic [2:0] ST_INSERTED  = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_READ_OK   = 3'd3;
    localparam logic [2:0] ST_READ_MISS = 3'd4;

    localparam logic [15:0] CID_PRIMARY   = 16'h004C;
    localparam logic [7:0]  SUB_PRIMARY   = 8'h12;
    localparam logic [15:0] CID_SECONDARY = 16'h000D;
    localparam logic [1:0]  MFR_LEN_ID    = 2'd2;
    localparam logic [1:0]  MFR_LEN_SUB   = 2'd3;

endpackage

`default_nettype wire

@@ src/bdtt_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bdtt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ src/bdtt_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bdtt_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire bdtt_pkg::sts_t sts,
    output bdtt_pkg::cmd_t     cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_READ   = 5'b00010,
        S_SEARCH = 5'b00100,
        S_UPDATE = 5'b01000,
        S_APPEND = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.start  = 1'b1;
                    state_next = sts.in_read ? S_READ : S_SEARCH;
                end
            end
            S_READ: begin
                if (sts.out_free) begin
                    cmd.emit_read = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_SEARCH: begin
                // compare the entry read last cycle, fetch the next one
                if (sts.pend && sts.match) begin
                    state_next = S_UPDATE;
                end else if (sts.pend && sts.more) begin
                    cmd.scan = 1'b1;
                end else begin
                    state_next = S_APPEND;
                end
            end
            S_UPDATE: begin
                if (sts.out_free) begin
                    cmd.emit_update = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_APPEND: begin
                if (sts.out_free) begin
                    cmd.emit_append = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign s_ready = (state_reg == S_IDLE);

    a_start_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.start |=> state_reg != S_IDLE)
        else $error("controller stayed idle after taking a beat");

    a_scan_needs_pend: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.scan |-> sts.pend && !sts.match)
        else $error("scan advanced past a match or without a pending compare");

    a_single_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.emit_read, cmd.emit_update, cmd.emit_append, cmd.start}))
        else $error("more than one emit or start in a cycle");

endmodule

`default_nettype wire

@@ src/bdtt_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bdtt_dp #(
    parameter int TABLE_DEPTH = 64
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire bdtt_pkg::in_t  s_data,
    input  wire bdtt_pkg::cmd_t cmd,
    output bdtt_pkg::sts_t      sts,
    output logic                m_valid,
    input  wire logic           m_ready,
    output bdtt_pkg::out_t      m_data
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int EW = $bits(bdtt_pkg::entry_t);

    bdtt_pkg::in_t    item_reg;
    bdtt_pkg::out_t   out_reg;
    bdtt_pkg::out_t   out_next;
    logic             out_valid_reg;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    rd_idx_reg;
    logic             pend_reg;
    logic [AW-1:0]    pend_idx_reg;

    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic [EW-1:0]    rd_data;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    bdtt_pkg::entry_t wr_entry;
    bdtt_pkg::entry_t rd_entry;
    bdtt_pkg::entry_t upd_entry;
    bdtt_pkg::entry_t new_entry;
    logic             full;
    logic             read_ok;
    logic             tracker;
    logic             out_load;

    bdtt_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_DEPTH)
    ) u_entry_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_entry = bdtt_pkg::entry_t'(rd_data);
    assign full     = (count_reg == CW'(TABLE_DEPTH));
    assign read_ok  = ({{CW{1'b0}}, item_reg.read_index} < {6'b0, count_reg});

    assign tracker = (item_reg.mfr_len >= bdtt_pkg::MFR_LEN_ID) &&
        (((item_reg.company_id == bdtt_pkg::CID_PRIMARY) &&
          (item_reg.mfr_len >= bdtt_pkg::MFR_LEN_SUB) &&
          (item_reg.mfr_subtype == bdtt_pkg::SUB_PRIMARY)) ||
         (item_reg.company_id == bdtt_pkg::CID_SECONDARY));

    // first read goes out in the accept cycle
    assign rd_en   = cmd.start | cmd.scan;
    assign rd_addr = cmd.start ?
        ((s_data.action == bdtt_pkg::ACT_READ) ? AW'(s_data.read_index) : '0) :
        rd_idx_reg[AW-1:0];

    always_comb begin
        upd_entry           = rd_entry;
        upd_entry.rssi      = item_reg.rssi;
        upd_entry.last_seen = item_reg.time_ms;

        new_entry.mac       = item_reg.mac;
        new_entry.rssi      = item_reg.rssi;
        new_entry.addr_type = item_reg.addr_type;
        new_entry.last_seen = item_reg.time_ms;
        new_entry.tracker   = tracker;
    end

    assign wr_en    = cmd.emit_update | (cmd.emit_append & ~full);
    assign wr_addr  = cmd.emit_update ? pend_idx_reg : count_reg[AW-1:0];
    assign wr_entry = cmd.emit_update ? upd_entry : new_entry;

    assign out_load = cmd.emit_read | cmd.emit_update | cmd.emit_append;

    always_comb begin
        out_next = out_reg;
        if (cmd.emit_read) begin
            out_next             = '0;
            out_next.entry_index = item_reg.read_index;
            out_next.entry_total = 7'(count_reg);
            if (read_ok) begin
                out_next.status        = bdtt_pkg::ST_READ_OK;
                out_next.out_mac       = rd_entry.mac;
                out_next.out_rssi      = rd_entry.rssi;
                out_next.out_addr_type = rd_entry.addr_type;
                out_next.out_last_seen = rd_entry.last_seen;
                out_next.out_tracker   = rd_entry.tracker;
            end else begin
                out_next.status = bdtt_pkg::ST_READ_MISS;
            end
        end else if (cmd.emit_update) begin
            out_next.status        = bdtt_pkg::ST_UPDATED;
            out_next.entry_index   = 6'(pend_idx_reg);
            out_next.entry_total   = 7'(count_reg);
            out_next.out_mac       = upd_entry.mac;
            out_next.out_rssi      = upd_entry.rssi;
            out_next.out_addr_type = upd_entry.addr_type;
            out_next.out_last_seen = upd_entry.last_seen;
            out_next.out_tracker   = upd_entry.tracker;
        end else if (cmd.emit_append) begin
            if (full) begin
                // drop: status FULL, echo the address and the entry count, everything else zero
                out_next             = '0;
                out_next.status      = bdtt_pkg::ST_FULL;
                out_next.entry_total = 7'(count_reg);
                out_next.out_mac     = item_reg.mac;
            end else begin
                out_next.status        = bdtt_pkg::ST_INSERTED;
                out_next.entry_index   = 6'(count_reg);
                out_next.entry_total   = 7'(count_reg + CW'(1));
                out_next.out_mac       = new_entry.mac;
                out_next.out_rssi      = new_entry.rssi;
                out_next.out_addr_type = new_entry.addr_type;
                out_next.out_last_seen = new_entry.last_seen;
                out_next.out_tracker   = new_entry.tracker;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            item_reg <= s_data;
        end
        if (cmd.start) begin
            pend_idx_reg <= '0;
        end else if (cmd.scan) begin
            pend_idx_reg <= rd_idx_reg[AW-1:0];
        end
        out_reg <= out_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            rd_idx_reg    <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.start) begin
                pend_reg   <= (count_reg != '0);
                rd_idx_reg <= CW'(1);
            end else if (cmd.scan) begin
                rd_idx_reg <= rd_idx_reg + CW'(1);
            end
            if (cmd.emit_append && !full) begin
                count_reg <= count_reg + CW'(1);
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb begin
        sts.in_read  = (s_data.action == bdtt_pkg::ACT_READ);
        sts.pend     = pend_reg;
        sts.match    = (rd_entry.mac == item_reg.mac);
        sts.more     = (rd_idx_reg < count_reg);
        sts.out_free = ~out_valid_reg | m_ready;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(TABLE_DEPTH))
        else $error("entry count above table depth");

    a_insert_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit_append && !full |=> count_reg == $past(count_reg) + CW'(1))
        else $error("insert did not advance the entry count");

    a_drop_only_full: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && (out_reg.status == bdtt_pkg::ST_FULL) |-> full)
        else $error("drop reported while the table has room");

endmodule

`default_nettype wire

@@ src/ble_device_table_tracker_flag.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Handshake          Beat
// -------  ---  -----------------  -----------------------------
// s_       in   s_valid / s_ready  bdtt_pkg::in_t  (report/read)
// m_       out  m_valid / m_ready  bdtt_pkg::out_t (one result)
//
// Report: the entry RAM has one read port, so the address search compares one entry
// per cycle. s_ready is high only while idle; a result waiting in the
// output register does not block the next accept, only the next result.
// aresetn (synchronous) empties the table; entry storage is not cleared.

module ble_device_table_tracker_flag #(
    parameter int TABLE_DEPTH = 64
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire bdtt_pkg::in_t  s_data,
    output logic                m_valid,
    input  wire logic           m_ready,
    output bdtt_pkg::out_t      m_data
);

    bdtt_pkg::cmd_t cmd;
    bdtt_pkg::sts_t sts;

    bdtt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    bdtt_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .sts     (sts),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire
